// ===== rtl/core/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, record and result types of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int ARR_W          = 16;
   localparam int BURST_W        = 16;
   localparam int PRIO_W         = 8;
   localparam int IDX_OUT_W      = 4;
   localparam int OUT_TIME_W     = 21;
   localparam int MAX_PROCS_DEF  = 16;

   // one process record as held in the record memory
   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] remaining;
   } rec_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0]  proc_index;
      logic [OUT_TIME_W-1:0] finish_time;
      logic [OUT_TIME_W-1:0] turnaround;
      logic [OUT_TIME_W-1:0] waiting;
      logic                  last_done;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } rsp_push_type;

endpackage

// ===== rtl/core/pps_if.sv =====
// ----------------------------------------------------------------------------
// pps_if
// Request and response channels of the scheduler, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pps_req_if;
   logic                         valid;
   logic                         ready;
   logic [pps_pkg::ARR_W-1:0]    arrival_time;
   logic [pps_pkg::BURST_W-1:0]  burst_length;
   logic [pps_pkg::PRIO_W-1:0]   prio_level;
   logic                         last_record;

   modport source (output valid, arrival_time, burst_length, prio_level, last_record,
                   input ready);
   modport sink (input valid, arrival_time, burst_length, prio_level, last_record,
                 output ready);
endinterface

interface pps_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pps_pkg::IDX_OUT_W-1:0]   proc_index;
   logic [pps_pkg::OUT_TIME_W-1:0]  finish_time;
   logic [pps_pkg::OUT_TIME_W-1:0]  turnaround;
   logic [pps_pkg::OUT_TIME_W-1:0]  waiting;
   logic                            last_done;

   modport source (output valid, proc_index, finish_time, turnaround, waiting, last_done,
                   input ready);
   modport sink (input valid, proc_index, finish_time, turnaround, waiting, last_done,
                 output ready);
endinterface

// ===== rtl/core/pps_out_reg.sv =====
// ----------------------------------------------------------------------------
// pps_out_reg
// Output register holding one finished result until the response side takes it.
// ----------------------------------------------------------------------------
module pps_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  pps_pkg::rsp_push_type push,
   output logic                  can_accept,
   pps_rsp_if.source             rsp
);

   logic                  valid_ff, valid_in;
   pps_pkg::rsp_item_type item_ff, item_in;

   assign can_accept = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (push.valid) begin
         valid_in = 1'b1;
         item_in  = push.item;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp.valid       = valid_ff;
   assign rsp.proc_index  = item_ff.proc_index;
   assign rsp.finish_time = item_ff.finish_time;
   assign rsp.turnaround  = item_ff.turnaround;
   assign rsp.waiting     = item_ff.waiting;
   assign rsp.last_done   = item_ff.last_done;

endmodule

// ===== rtl/core/pps_engine.sv =====
// ----------------------------------------------------------------------------
// pps_engine
// Record memory, scan sequencer and run/complete arithmetic of the scheduler.
// ----------------------------------------------------------------------------
module pps_engine #(
   parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   pps_req_if.sink               req,
   input  logic                  can_accept,
   output pps_pkg::rsp_push_type push
);

   localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int TIME_W = pps_pkg::ARR_W + CNT_W;
   localparam int ARR_W  = pps_pkg::ARR_W;
   localparam int BST_W  = pps_pkg::BURST_W;
   localparam int PRI_W  = pps_pkg::PRIO_W;

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   // record memory
   pps_pkg::rec_type rec_mem [MAX_PROCS];
   pps_pkg::rec_type rd_data_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   pps_pkg::rec_type mem_wdata;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     loaded_ff, loaded_in;
   logic [CNT_W-1:0]     fin_cnt_ff, fin_cnt_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [MAX_PROCS-1:0] adm_ff, adm_in;
   logic [MAX_PROCS-1:0] fin_ff, fin_in;
   logic [CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [PRI_W-1:0]     best_prio_ff, best_prio_in;
   logic                 next_valid_ff, next_valid_in;
   logic [ARR_W-1:0]     next_arr_ff, next_arr_in;
   logic [ARR_W-1:0]     gap_ff, gap_in;
   logic [ARR_W-1:0]     arr_ff, arr_in;
   logic [ARR_W:0]       ab_sum_ff, ab_sum_in;

   logic                 req_fire;
   logic                 scan_done;
   logic                 adm_now;
   logic [BST_W-1:0]     run_len;
   logic [BST_W-1:0]     new_rem;
   logic [TIME_W-1:0]    tat_full, wt_full;

   assign req.ready = (state_ff == ST_LOAD);
   assign req_fire  = req.valid && req.ready;
   assign scan_done = (scan_idx_ff == loaded_ff) && !rd_valid_ff;

   // an entry counts as admitted once its arrival is at or before the current time
   assign adm_now = adm_ff[rd_idx_ff] || (TIME_W'(rd_data_ff.arrival) <= time_ff);

   assign run_len = (next_valid_ff && (gap_ff < rd_data_ff.remaining)) ? gap_ff
                                                                      : rd_data_ff.remaining;
   assign new_rem = rd_data_ff.remaining - run_len;

   assign tat_full = time_ff - TIME_W'(arr_ff);
   assign wt_full  = time_ff - TIME_W'(ab_sum_ff);

   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      fin_cnt_in    = fin_cnt_ff;
      time_in       = time_ff;
      adm_in        = adm_ff;
      fin_in        = fin_ff;
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = rd_idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_prio_in  = best_prio_ff;
      next_valid_in = next_valid_ff;
      next_arr_in   = next_arr_ff;
      gap_in        = gap_ff;
      arr_in        = arr_ff;
      ab_sum_in     = ab_sum_ff;
      mem_we        = 1'b0;
      mem_waddr     = loaded_ff[IDX_W-1:0];
      mem_wdata     = rd_data_ff;
      mem_raddr     = best_idx_ff;
      push.valid    = 1'b0;
      push.item.proc_index  = pps_pkg::IDX_OUT_W'(best_idx_ff);
      push.item.finish_time = pps_pkg::OUT_TIME_W'(time_ff);
      push.item.turnaround  = pps_pkg::OUT_TIME_W'(tat_full);
      push.item.waiting     = pps_pkg::OUT_TIME_W'(wt_full);
      push.item.last_done   = (fin_cnt_ff == loaded_ff);

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (loaded_ff < CNT_W'(MAX_PROCS)) begin
                  mem_we              = 1'b1;
                  mem_wdata.arrival   = req.arrival_time;
                  mem_wdata.burst     = req.burst_length;
                  mem_wdata.prio      = req.prio_level;
                  // a zero burst is served as one tick
                  mem_wdata.remaining = (req.burst_length == '0) ? BST_W'(1)
                                                                  : req.burst_length;
                  loaded_in           = loaded_ff + CNT_W'(1);
               end
               if (req.last_record) begin
                  state_in      = ST_SCAN;
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
                  next_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff != loaded_ff) begin
               mem_raddr   = scan_idx_ff[IDX_W-1:0];
               rd_valid_in = 1'b1;
               rd_idx_in   = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
            if (rd_valid_ff) begin
               adm_in[rd_idx_ff] = adm_now;
               if (!adm_now) begin
                  if (!next_valid_ff || (rd_data_ff.arrival < next_arr_ff)) begin
                     next_valid_in = 1'b1;
                     next_arr_in   = rd_data_ff.arrival;
                  end
               end else if (!fin_ff[rd_idx_ff]) begin
                  // strict compare keeps ties at the lower index
                  if (!best_valid_ff || (rd_data_ff.prio < best_prio_ff)) begin
                     best_valid_in = 1'b1;
                     best_idx_in   = rd_idx_ff;
                     best_prio_in  = rd_data_ff.prio;
                  end
               end
            end
            if (scan_done) begin
               gap_in = ARR_W'(TIME_W'(next_arr_ff) - time_ff);
               if (best_valid_ff) begin
                  mem_raddr = best_idx_ff;
                  state_in  = ST_RUN;
               end else if (next_valid_ff) begin
                  // idle stretch: jump straight to the next arrival
                  time_in       = TIME_W'(next_arr_ff);
                  scan_idx_in   = '0;
                  next_valid_in = 1'b0;
               end else begin
                  state_in   = ST_LOAD;
                  loaded_in  = '0;
                  fin_cnt_in = '0;
                  time_in    = '0;
                  adm_in     = '0;
                  fin_in     = '0;
               end
            end
         end
         ST_RUN: begin
            mem_we              = 1'b1;
            mem_waddr           = best_idx_ff;
            mem_wdata.remaining = new_rem;
            time_in             = time_ff + TIME_W'(run_len);
            arr_in              = rd_data_ff.arrival;
            ab_sum_in           = (ARR_W + 1)'(rd_data_ff.arrival)
                                  + (ARR_W + 1)'(rd_data_ff.burst);
            if (new_rem == '0) begin
               fin_in[best_idx_ff] = 1'b1;
               fin_cnt_in          = fin_cnt_ff + CNT_W'(1);
               state_in            = ST_EMIT;
            end else begin
               state_in      = ST_SCAN;
               scan_idx_in   = '0;
               best_valid_in = 1'b0;
               next_valid_in = 1'b0;
            end
         end
         ST_EMIT: begin
            if (can_accept) begin
               push.valid = 1'b1;
               if (fin_cnt_ff == loaded_ff) begin
                  state_in   = ST_LOAD;
                  loaded_in  = '0;
                  fin_cnt_in = '0;
                  time_in    = '0;
                  adm_in     = '0;
                  fin_in     = '0;
               end else begin
                  state_in      = ST_SCAN;
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
                  next_valid_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= rec_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         loaded_ff     <= '0;
         fin_cnt_ff    <= '0;
         time_ff       <= '0;
         adm_ff        <= '0;
         fin_ff        <= '0;
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         next_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loaded_ff     <= loaded_in;
         fin_cnt_ff    <= fin_cnt_in;
         time_ff       <= time_in;
         adm_ff        <= adm_in;
         fin_ff        <= fin_in;
         scan_idx_ff   <= scan_idx_in;
         rd_valid_ff   <= rd_valid_in;
         best_valid_ff <= best_valid_in;
         next_valid_ff <= next_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
      next_arr_ff  <= next_arr_in;
      gap_ff       <= gap_in;
      arr_ff       <= arr_in;
      ab_sum_ff    <= ab_sum_in;
   end

   a_fin_count: assert property (@(posedge clock) disable iff (reset)
      $countones(fin_ff) == 32'(fin_cnt_ff))
      else $error("finished count disagrees with finished flags");

   a_fin_admitted: assert property (@(posedge clock) disable iff (reset)
      (fin_ff & ~adm_ff) == '0)
      else $error("process finished without being admitted");

   a_fin_bound: assert property (@(posedge clock) disable iff (reset)
      fin_cnt_ff <= loaded_ff)
      else $error("more processes finished than loaded");

   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (time_ff == '0 && fin_ff == '0 && adm_ff == '0))
      else $error("batch state not cleared while loading");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> can_accept)
      else $error("result pushed into a full output register");

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler. Process records (arrival, burst, priority) are taken one
// request per cycle into a record memory of MAX_PROCS entries; a record beyond that is
// dropped. The record flagged last starts a unit-tick simulation and no request is taken
// until it ends. Each scheduling step scans all n loaded records through the memory's single
// read port, one per cycle, and each result handed to the output register waits while the
// response side stalls. Runs of ticks without an arrival or completion are taken in one
// step, so a batch needs at most about 2n steps. Results leave in completion order and the
// final one of a batch carries last_done.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Top level: record memory engine followed by the result output register.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pps_req_if.sink    req_chan,
   pps_rsp_if.source  rsp_chan
);

   pps_pkg::rsp_push_type push;
   logic                  can_accept;

   pps_engine #(
      .MAX_PROCS (MAX_PROCS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .can_accept (can_accept),
      .push       (push)
   );

   pps_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .can_accept (can_accept),
      .rsp        (rsp_chan)
   );

endmodule
